// ===== sv/h2r_pkg.sv =====
// h2r_pkg: shared types and constants for the hsv to rgb converter
// no dependencies; imported by h2r_level and hsv_to_rgb_converter

package h2r_pkg;

	localparam int FRAC_W = 17;
	localparam int FR_W   = 16;
	localparam int WGT_W  = 33;
	localparam int PROD_W = FRAC_W + WGT_W;
	localparam int CH_W   = 8;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
	localparam logic [WGT_W-1:0]  WGT_ONE  = 33'h1_0000_0000;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		logic [FRAC_W-1:0] hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] brightness;
		logic              last_cell;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last_out;
	} rgb_t;

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: four-stage pipelined hsv to 8-bit rgb conversion
// depends on h2r_pkg and h2r_level

// Takes one cell per clock while the output side does not stall and gives one
// rgb result per cell, in order. Stage one clamps saturation and value and
// splits hue into sector and fraction, stage two forms the p, q and t weights,
// stage three multiplies each weight by value, stage four scales to 8 bits and
// routes the terms by sector into the output register. A stall holds each full
// stage that has only full stages after it; empty stages still fill.

module hsv_to_rgb_converter import h2r_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic hsv_valid,
	output logic hsv_stall,
	input  hsv_t hsv,
	output logic rgb_valid,
	input  logic rgb_stall,
	output rgb_t rgb
);

	logic en1, en2, en3, en4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// stage 1 signals
	logic [FRAC_W-1:0] sat_c, val_c;
	logic [19:0]       h6;
	logic              hue_in_range;
	sector_t           sector_c;
	logic [FR_W-1:0]   fr_c;

	logic [FRAC_W-1:0] sat_s1, val_s1;
	sector_t           sector_s1;
	logic [FR_W-1:0]   fr_s1;
	logic              last_s1;

	// stage 2 signals
	logic [WGT_W-1:0]  sfr, sinv;
	logic [WGT_W-1:0]  wp_s2, wq_s2, wt_s2;
	logic [FRAC_W-1:0] val_s2;
	sector_t           sector_s2;
	logic              last_s2;

	// stage 3 signals
	logic [FRAC_W-1:0] val_s3;
	sector_t           sector_s3;
	logic              last_s3;

	// stage 4 signals
	logic [CH_W-1:0] p_lvl, q_lvl, t_lvl, top_lvl;
	logic [33:0]     top_sum;
	rgb_t            rgb_c;
	rgb_t            rgb_s4;

	// pipeline flow control
	always_comb begin
		en4       = !valid_s4 || !rgb_stall;
		en3       = !valid_s3 || en4;
		en2       = !valid_s2 || en3;
		en1       = !valid_s1 || en2;
		hsv_stall = !en1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= hsv_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: clamp, sector and fraction
	always_comb begin
		sat_c = (hsv.saturation > FRAC_ONE) ? FRAC_ONE : hsv.saturation;
		val_c = (hsv.brightness > FRAC_ONE) ? FRAC_ONE : hsv.brightness;
		hue_in_range = !hsv.hue[FRAC_W-1] && (hsv.hue[FR_W-1:0] != '0);
		h6 = {1'b0, hsv.hue[FR_W-1:0], 3'd0} - {4'd0, hsv.hue[FR_W-1:0]}
		     - {4'd0, hsv.hue[FR_W-1:0]};
		if (hue_in_range) begin
			sector_c = sector_t'(h6[18:16]);
			fr_c     = h6[FR_W-1:0];
		end else begin
			sector_c = SEC_RED;
			fr_c     = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sat_s1    <= sat_c;
			val_s1    <= val_c;
			sector_s1 <= sector_c;
			fr_s1     <= fr_c;
			last_s1   <= hsv.last_cell;
		end
	end

	// stage 2: weights 1-s, 1-s*f, 1-s*(1-f) with 32 fraction bits
	always_comb begin
		sfr  = WGT_W'(sat_s1) * WGT_W'(fr_s1);
		sinv = WGT_W'(sat_s1) * WGT_W'(FRAC_ONE - {1'b0, fr_s1});
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			wp_s2     <= {FRAC_ONE - sat_s1, 16'd0};
			wq_s2     <= WGT_ONE - sfr;
			wt_s2     <= WGT_ONE - sinv;
			val_s2    <= val_s1;
			sector_s2 <= sector_s1;
			last_s2   <= last_s1;
		end
	end

	// stage 3: value times weight, registered inside each channel unit
	h2r_level u_p (.clk(clk), .en(en3), .v(val_s2), .w(wp_s2), .level(p_lvl));
	h2r_level u_q (.clk(clk), .en(en3), .v(val_s2), .w(wq_s2), .level(q_lvl));
	h2r_level u_t (.clk(clk), .en(en3), .v(val_s2), .w(wt_s2), .level(t_lvl));

	always_ff @(posedge clk) begin
		if (en3) begin
			val_s3    <= val_s2;
			sector_s3 <= sector_s2;
			last_s3   <= last_s2;
		end
	end

	// stage 4: full-weight level and sector routing
	always_comb begin
		top_sum  = {1'b0, val_s3, 16'd0} - 34'(val_s3) + 34'd32768;
		top_lvl  = top_sum[31:24];
		rgb_c.last_out = last_s3;
		unique case (sector_s3)
			SEC_YELLOW: begin
				rgb_c.red = q_lvl; rgb_c.green = top_lvl; rgb_c.blue = p_lvl;
			end
			SEC_GREEN: begin
				rgb_c.red = p_lvl; rgb_c.green = top_lvl; rgb_c.blue = t_lvl;
			end
			SEC_CYAN: begin
				rgb_c.red = p_lvl; rgb_c.green = q_lvl; rgb_c.blue = top_lvl;
			end
			SEC_BLUE: begin
				rgb_c.red = t_lvl; rgb_c.green = p_lvl; rgb_c.blue = top_lvl;
			end
			SEC_MAGENTA: begin
				rgb_c.red = top_lvl; rgb_c.green = p_lvl; rgb_c.blue = q_lvl;
			end
			default: begin
				rgb_c.red = top_lvl; rgb_c.green = t_lvl; rgb_c.blue = p_lvl;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			rgb_s4 <= rgb_c;
		end
	end

	assign rgb_valid = valid_s4;
	assign rgb       = rgb_s4;

	// a blocked full stage keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !en4 |=> valid_s3 && $stable(sector_s3) && $stable(last_s3))
		else $error("stage 3 lost its item while blocked");

	// an accepted cell lands in stage 1
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_stall |=> valid_s1)
		else $error("transfer did not reach stage 1");

	// weights stay within 1.0
	a_wgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> wp_s2 <= WGT_ONE && wq_s2 <= WGT_ONE && wt_s2 <= WGT_ONE)
		else $error("weight above one");

	// the sector code is always one of the six sectors
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> sector_s1 <= SEC_MAGENTA)
		else $error("sector out of range");

endmodule

// ===== sv/h2r_level.sv =====
// h2r_level: one channel term, value times weight registered, then scaled to 8 bits
// depends on h2r_pkg

module h2r_level import h2r_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [FRAC_W-1:0] v,
	input  logic [WGT_W-1:0]  w,
	output logic [CH_W-1:0]   level
);

	logic [PROD_W-1:0] prod_s3;
	logic [65:0]       scaled;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(v) * PROD_W'(w);
		end
	end

	// 65535 * m + 2^47, level is bits 63:48, keep its upper byte
	always_comb begin
		scaled = {prod_s3, 16'd0} - 66'(prod_s3) + (66'd1 << 47);
		level  = scaled[63:56];
	end

endmodule
